### rtl/lkx_pkg.sv
`default_nettype none

package lkx_pkg;

    localparam int WORD_W   = 31;
    localparam int BYTE_W   = 8;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int DVD_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MULT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd3;

    localparam logic [WORD_W-1:0] MULT_RST    = 31'd1;
    localparam logic [WORD_W-1:0] INCR_RST    = 31'd0;
    localparam logic [WORD_W-1:0] MODULUS_RST = 31'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SEED_RST    = 31'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } rem_rsp_t;

endpackage

`default_nettype wire

### rtl/lcg_keystream_xor_cipher.sv
// Linear congruential keystream XOR cipher.
// Input channel: drive data_byte, first, last and raise push; a transfer
// happens on a rising edge with push high and full low. A two-entry queue
// holds items ahead of the keystream engine.
// Output channel: while empty is low, out_byte and out_last hold the oldest
// result; it transfers on a rising edge with pop high. A stalled result holds
// and the input queue keeps taking items until it fills.
// Configuration: cfg_wen with cfg_index (0 mult, 1 incr, 2 modulus,
// 3 seed_word) and cfg_data writes a register on that edge.
// Path: with the engine idle, an input item passes from the input queue into
// the output register, from which it can transfer out.
// Throughput: one item per cycle within a word while no result is stalled;
// after the last byte of a word the engine takes no items while it steps
// to the next word (one multiply, one add, a restoring remainder at one
// quotient bit per cycle); with modulus zero the remainder is skipped.
// Reset: registers return to mult 1, incr 0, modulus 2^31-1, seed 0; the
// stream restarts at key word 0, byte 0; both queues empty.
`default_nettype none

module lcg_keystream_xor_cipher
#(
    parameter int WORD_BYTES = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [lkx_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                          first,
    input  wire logic                          last,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [lkx_pkg::BYTE_W-1:0]         out_byte,
    output logic                               out_last,
    input  wire logic                          cfg_wen,
    input  wire logic [lkx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lkx_pkg::WORD_W-1:0]    cfg_data
);

    lkx_pkg::item_t in_item;
    lkx_pkg::item_t q_item;
    logic           q_valid;
    logic           q_take;

    assign in_item.data  = data_byte;
    assign in_item.first = first;
    assign in_item.last  = last;

    lkx_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    lkx_back
    #(
        .WORD_BYTES (WORD_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

### rtl/lkx_front.sv
`default_nettype none

module lkx_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire lkx_pkg::item_t in_item,
    output logic               q_valid,
    output lkx_pkg::item_t     q_item,
    input  wire logic          q_take
);

    lkx_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_take;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_take = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_take) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("push transfer not counted");

    a_take_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_take && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("take transfer not counted");

endmodule

`default_nettype wire

### rtl/lkx_rem.sv
`default_nettype none

module lkx_rem
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lkx_pkg::rem_req_t req,
    output lkx_pkg::rem_rsp_t      rsp
);

    localparam int CNT_W = $clog2(lkx_pkg::DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lkx_pkg::DVD_W - 1);

    logic [lkx_pkg::DVD_W-1:0]  dvd_reg;
    logic [lkx_pkg::WORD_W:0]   r_reg;
    logic [lkx_pkg::WORD_W-1:0] d_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [lkx_pkg::WORD_W:0]   trial;
    logic [lkx_pkg::WORD_W:0]   d_ext;

    assign d_ext = {1'b0, d_reg};
    assign trial = {r_reg[lkx_pkg::WORD_W-1:0], dvd_reg[lkx_pkg::DVD_W-1]};

    assign rsp.done = done_reg;
    assign rsp.rem  = r_reg[lkx_pkg::WORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= '0;
                if (req.divisor == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            d_reg   <= req.divisor;
            if (req.divisor == '0)
            begin
                r_reg <= {1'b0, req.dividend[lkx_pkg::WORD_W-1:0]};
            end
            else
            begin
                r_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[lkx_pkg::DVD_W-2:0], 1'b0};
            if (trial >= d_ext)
            begin
                r_reg <= trial - d_ext;
            end
            else
            begin
                r_reg <= trial;
            end
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still stepping");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && d_reg != '0) |-> (r_reg < d_ext))
        else $error("remainder not below divisor");

    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg != LAST_STEP) |=> busy_reg)
        else $error("remainder stopped early");

endmodule

`default_nettype wire

### rtl/lkx_back.sv
`default_nettype none

module lkx_back
#(
    parameter int WORD_BYTES = 4
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [lkx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lkx_pkg::WORD_W-1:0]      cfg_data,
    input  wire logic                            q_valid,
    input  wire lkx_pkg::item_t                  q_item,
    output logic                                 q_take,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [lkx_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 out_last
);

    localparam int POS_W = $clog2(WORD_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_BYTES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIVS = 2'd2;
    localparam logic [1:0] ST_DIVW = 2'd3;

    logic [lkx_pkg::WORD_W-1:0] mult_reg;
    logic [lkx_pkg::WORD_W-1:0] incr_reg;
    logic [lkx_pkg::WORD_W-1:0] modulus_reg;
    logic [lkx_pkg::WORD_W-1:0] seed_reg;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [lkx_pkg::WORD_W-1:0] key_reg;
    logic [lkx_pkg::WORD_W-1:0] key_next;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [lkx_pkg::PROD_W-1:0] prod_reg;
    logic                       ovalid_reg;
    logic                       ovalid_next;
    logic [lkx_pkg::BYTE_W-1:0] obyte_reg;
    logic                       olast_reg;

    logic [lkx_pkg::WORD_W-1:0] cur_key;
    logic [POS_W-1:0]           cur_pos;
    logic [63:0]                key_wide;
    logic [lkx_pkg::BYTE_W-1:0] kbyte;
    logic                       out_free;

    lkx_pkg::rem_req_t          rem_req;
    lkx_pkg::rem_rsp_t          rem_rsp;

    lkx_rem u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign empty    = !ovalid_reg;
    assign out_byte = obyte_reg;
    assign out_last = olast_reg;
    assign out_free = !ovalid_reg || pop;
    assign q_take   = (state_reg == ST_IDLE) && q_valid && out_free;

    assign cur_key  = q_item.first ? seed_reg : key_reg;
    assign cur_pos  = q_item.first ? '0 : pos_reg;
    assign key_wide = 64'(cur_key);
    assign kbyte    = 8'(key_wide >> {cur_pos, 3'b000});

    assign rem_req.start    = (state_reg == ST_DIVS);
    assign rem_req.dividend = lkx_pkg::DVD_W'(prod_reg) + lkx_pkg::DVD_W'(incr_reg);
    assign rem_req.divisor  = modulus_reg;

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && !pop;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_take)
                begin
                    ovalid_next = 1'b1;
                    key_next    = cur_key;
                    if (cur_pos == LAST_POS)
                    begin
                        pos_next   = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        pos_next = cur_pos + POS_W'(1);
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (rem_rsp.done)
                begin
                    key_next   = rem_rsp.rem;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            key_reg     <= '0;
            pos_reg     <= '0;
            ovalid_reg  <= 1'b0;
            mult_reg    <= lkx_pkg::MULT_RST;
            incr_reg    <= lkx_pkg::INCR_RST;
            modulus_reg <= lkx_pkg::MODULUS_RST;
            seed_reg    <= lkx_pkg::SEED_RST;
        end
        else
        begin
            state_reg  <= state_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    lkx_pkg::REG_MULT:    mult_reg    <= cfg_data;
                    lkx_pkg::REG_INCR:    incr_reg    <= cfg_data;
                    lkx_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                    lkx_pkg::REG_SEED:    seed_reg    <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= {{lkx_pkg::WORD_W{1'b0}}, mult_reg} *
                        {{lkx_pkg::WORD_W{1'b0}}, key_reg};
        end
        if (q_take)
        begin
            obyte_reg <= q_item.data ^ kbyte;
            olast_reg <= q_item.last;
        end
    end

    a_no_take_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_take)
        else $error("item taken during word step");

    a_step_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (q_take && cur_pos == LAST_POS) |=> (state_reg == ST_MUL && pos_reg == '0))
        else $error("word step not started after last byte");

    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVW && rem_rsp.done) |=> (state_reg == ST_IDLE))
        else $error("word step did not finish");

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BYTES = 4;
    localparam logic [lkx_pkg::WORD_W-1:0] WORD_MAX = 31'h7FFF_FFFF;
    localparam int PHASE_ITEMS = 225;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [lkx_pkg::BYTE_W-1:0] data;
        logic                       last;
    } cipher_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [lkx_pkg::BYTE_W-1:0]    data_byte = '0;
    logic                          first = 1'b0;
    logic                          last = 1'b0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [lkx_pkg::BYTE_W-1:0]    out_byte;
    logic                          out_last;
    logic                          cfg_wen = 1'b0;
    logic [lkx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lkx_pkg::WORD_W-1:0]    cfg_data = '0;

    lcg_keystream_xor_cipher #(.WORD_BYTES(WORD_BYTES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .first     (first),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // keystream state and register copies
    logic [lkx_pkg::WORD_W-1:0] mult_r = lkx_pkg::MULT_RST;
    logic [lkx_pkg::WORD_W-1:0] incr_r = lkx_pkg::INCR_RST;
    logic [lkx_pkg::WORD_W-1:0] mod_r  = lkx_pkg::MODULUS_RST;
    logic [lkx_pkg::WORD_W-1:0] seed_r = lkx_pkg::SEED_RST;
    logic [lkx_pkg::WORD_W-1:0] key_w  = '0;
    int                         key_pos = 0;

    lkx_pkg::item_t pending[$];
    cipher_t        cipher_q[$];

    int errors = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    bit idle_on = 1'b1;
    bit in_took = 1'b0;

    initial forever #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [lkx_pkg::WORD_W-1:0] lcg_next(
        input logic [lkx_pkg::WORD_W-1:0] prev);
        logic [63:0] acc;
        acc = 64'(mult_r) * 64'(prev) + 64'(incr_r);
        if (mod_r != '0)
        begin
            acc = acc % 64'(mod_r);
        end
        return acc[lkx_pkg::WORD_W-1:0];
    endfunction

    task automatic predict_cipher(input logic [lkx_pkg::BYTE_W-1:0] d, input logic f,
                                  input logic l);
        cipher_t     c;
        logic [31:0] kw;
        if (f)
        begin
            key_w   = seed_r;
            key_pos = 0;
        end
        if (key_pos >= WORD_BYTES)
        begin
            key_pos = 0;
        end
        kw     = {1'b0, key_w};
        c.data = d ^ ((key_pos < 4) ? kw[8*key_pos +: 8] : 8'h00);
        c.last = l;
        cipher_q.push_back(c);
        key_pos++;
        if (key_pos >= WORD_BYTES)
        begin
            key_pos = 0;
            key_w   = lcg_next(key_w);
        end
    endtask

    function automatic void queue_item(input logic [lkx_pkg::BYTE_W-1:0] d, input logic f,
                                       input logic l);
        lkx_pkg::item_t it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        pending.push_back(it);
    endfunction

    // input side: record transfers at the rising edge
    always @(posedge clk)
    begin
        in_took = 1'b0;
        if (rst_n && push && !full)
        begin
            in_took = 1'b1;
            predict_cipher(data_byte, first, last);
        end
    end

    // input side: offer the next item at the falling edge
    always @(negedge clk)
    begin
        lkx_pkg::item_t nxt;
        if (rst_n && (!push || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                nxt = pending.pop_front();
                push      <= 1'b1;
                data_byte <= nxt.data;
                first     <= nxt.first;
                last      <= nxt.last;
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 5);
                end
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // output side: count down the long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_left = LONG_HOLD;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
        end
    end

    // output side: pop with random stalls, hold off while the long hold runs
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(1, 5);
            end
        end
    end

    // output side: compare each transfer with the oldest expected byte
    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && pop && !empty)
        begin
            if (cipher_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %h last %b",
                                          out_byte, out_last));
            end
            else
            begin
                want = cipher_q.pop_front();
                if (out_byte !== want.data)
                begin
                    report_mismatch($sformatf("out_byte %h, expected %h", out_byte,
                                              want.data));
                end
                if (out_last !== want.last)
                begin
                    report_mismatch($sformatf("out_last %b, expected %b", out_last,
                                              want.last));
                end
            end
        end
    end

    task automatic write_reg(input logic [lkx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lkx_pkg::WORD_W-1:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            lkx_pkg::REG_MULT:    mult_r = val;
            lkx_pkg::REG_INCR:    incr_r = val;
            lkx_pkg::REG_MODULUS: mod_r  = val;
            lkx_pkg::REG_SEED:    seed_r = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [lkx_pkg::WORD_W-1:0] m,
                             input logic [lkx_pkg::WORD_W-1:0] i,
                             input logic [lkx_pkg::WORD_W-1:0] md,
                             input logic [lkx_pkg::WORD_W-1:0] s);
        write_reg(lkx_pkg::REG_MULT, m);
        write_reg(lkx_pkg::REG_INCR, i);
        write_reg(lkx_pkg::REG_MODULUS, md);
        write_reg(lkx_pkg::REG_SEED, s);
    endtask

    // drain all traffic, then let the next-word engine settle
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending.size() != 0 || push || cipher_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [lkx_pkg::WORD_W-1:0] pick_word(input bit allow_zero);
        case ($urandom_range(0, 6))
            0:       return allow_zero ? '0 : 31'd1;
            1:       return 31'd1;
            2:       return WORD_MAX;
            3:       return 31'($urandom_range(2, 255));
            4:       return 31'($urandom_range(256, 65535));
            default: return 31'($urandom) & WORD_MAX;
        endcase
    endfunction

    task automatic fill_phase(input int n);
        int count;
        int len;
        count = 0;
        // continue the stream across the register change
        for (int k = 0; k < 3; k++)
        begin
            queue_item(8'($urandom), 1'b0, 1'b0);
        end
        while (count < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    queue_item(8'($urandom), k == 0, k == len - 1);
                end
                count += len;
            end
            else
            begin
                queue_item(8'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stream from reset state, no restart
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b1);
        queue_item(8'h55, 1'b0, 1'b0);
        queue_item(8'hAA, 1'b0, 1'b0);
        queue_item(8'h0F, 1'b0, 1'b1);
        wait_idle();

        // seed equal to modulus, restart mid-word, stream continues past last
        write_all(31'd1103515245, 31'd12345, WORD_MAX, WORD_MAX);
        queue_item(8'h12, 1'b1, 1'b0);
        queue_item(8'h34, 1'b0, 1'b0);
        queue_item(8'h56, 1'b0, 1'b0);
        queue_item(8'h78, 1'b0, 1'b1);
        queue_item(8'h9A, 1'b0, 1'b0);
        queue_item(8'hBC, 1'b0, 1'b1);
        queue_item(8'hDE, 1'b1, 1'b0);
        queue_item(8'hF0, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h01, 1'b0, 1'b1);
        wait_idle();

        // modulus zero with maximal multiplier and increment
        write_all(WORD_MAX, WORD_MAX, '0, 31'h1234_5678);
        for (int k = 0; k < 9; k++)
        begin
            queue_item(8'($urandom), k == 0, k == 8);
        end
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       write_all('0, '0, 31'd1, '0);
                1:       write_all(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
                default: write_all(pick_word(1'b1), pick_word(1'b1), pick_word(1'b1),
                                   pick_word(1'b1));
            endcase
            idle_on = (ph != 7);
            if (ph == 3)
            begin
                hold_req = 1'b1;
            end
            fill_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (cipher_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", cipher_q.size()));
        end
        if (errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/lkx_pkg.sv
rtl/lkx_front.sv
rtl/lkx_rem.sv
rtl/lkx_back.sv
rtl/lcg_keystream_xor_cipher.sv
dv/tb.sv
